@@ rtl/core/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion shorthands clocked on clk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/takf_pkg.sv @@
// ----------------------------------------------------------------------------
// Tilt angle Kalman filter package
// Widths, formats, register indexes, reset values and saturation helpers.
// ----------------------------------------------------------------------------
package takf_pkg;

  localparam int DATA_W    = 32;
  localparam int CFG_W     = 32;
  localparam int COV_W     = 48;
  localparam int CFG_FRAC  = 24;
  localparam int COV_FRAC  = 32;
  localparam int CFG_SHIFT = COV_FRAC - CFG_FRAC;
  localparam int CFG_PAD_W = COV_W - CFG_W - CFG_SHIFT;
  localparam int SUM_W     = COV_W + 3;
  localparam int OPND_W    = COV_W + 1;
  localparam int PROD_W    = 2 * COV_W;
  localparam int DIGIT_W   = 16;
  localparam int CFG_IDX_W = 8;

  typedef logic signed [DATA_W-1:0] data_t;
  typedef logic signed [COV_W-1:0]  cov_t;
  typedef logic signed [SUM_W-1:0]  wide_t;
  typedef logic signed [OPND_W-1:0] opnd_t;
  typedef logic [CFG_W-1:0]         cfg_t;
  typedef logic [CFG_IDX_W-1:0]     cfg_idx_t;

  localparam cfg_idx_t REG_ANGLE_NOISE = 8'd0;
  localparam cfg_idx_t REG_BIAS_NOISE  = 8'd1;
  localparam cfg_idx_t REG_MEAS_NOISE  = 8'd2;
  localparam cfg_idx_t REG_TIME_STEP   = 8'd3;

  localparam cfg_t RST_ANGLE_NOISE = 32'd1678;
  localparam cfg_t RST_BIAS_NOISE  = 32'd50332;
  localparam cfg_t RST_MEAS_NOISE  = 32'd335544320;
  localparam cfg_t RST_TIME_STEP   = 32'd83886;

  localparam cov_t COV_ONE = cov_t'({1'b1, {COV_FRAC{1'b0}}});

  function automatic cov_t sat_cov(wide_t v);
    wide_t hi;
    wide_t lo;
    hi = wide_t'({1'b0, {(COV_W-1){1'b1}}});
    lo = ~hi;
    if (v > hi) return hi[COV_W-1:0];
    if (v < lo) return lo[COV_W-1:0];
    return v[COV_W-1:0];
  endfunction

  function automatic data_t sat_data(wide_t v);
    wide_t hi;
    wide_t lo;
    hi = wide_t'({1'b0, {(DATA_W-1){1'b1}}});
    lo = ~hi;
    if (v > hi) return hi[DATA_W-1:0];
    if (v < lo) return lo[DATA_W-1:0];
    return v[DATA_W-1:0];
  endfunction

endpackage

@@ rtl/core/tilt_angle_kalman_filter_unit.sv @@
// ----------------------------------------------------------------------------
// Tilt angle Kalman filter unit
// Two-state angle/gyro-bias Kalman filter on one shared digit-serial
// multiplier and one shared radix-2 divider under a small sequencer.
// ----------------------------------------------------------------------------
//   channel | direction | handshake               | payload
//   in      | input     | in_valid / in_ready     | accel_angle, gyro_rate
//   out     | output    | out_valid / out_ready   | filtered_angle, corrected_rate
//   cfg     | input     | cfg_wr_en               | cfg_index, cfg_wdata
//
// Each sample runs, from the accepted beat to the result load, eleven multiplies
// on the 48x16 multiplier, a setup step, two divisions on the bit-serial
// divider (cut short when the gain saturates or the innovation variance is
// zero) and a final step. The next beat is taken at the earliest once the
// sequencer is back in idle, so samples do not overlap.
// in_ready is high only while the sequencer is idle. The result is held in an
// output register, so the next sample is taken while a result waits; a full
// output register stalls only the final result load.
// Reset (synchronous) restores registers, estimates and the identity covariance.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tilt_angle_kalman_filter_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  takf_pkg::data_t               in_accel_angle,
  input  takf_pkg::data_t               in_gyro_rate,
  output logic                          out_valid,
  input  logic                          out_ready,
  output takf_pkg::data_t               out_filtered_angle,
  output takf_pkg::data_t               out_corrected_rate,
  input  logic                          cfg_wr_en,
  input  takf_pkg::cfg_idx_t            cfg_index,
  input  takf_pkg::cfg_t                cfg_wdata
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_MUL    = 3'd1;
  localparam logic [2:0] ST_MAPPLY = 3'd2;
  localparam logic [2:0] ST_PREP   = 3'd3;
  localparam logic [2:0] ST_DSET   = 3'd4;
  localparam logic [2:0] ST_DIV    = 3'd5;
  localparam logic [2:0] ST_DFIN   = 3'd6;
  localparam logic [2:0] ST_DONE   = 3'd7;

  localparam logic [3:0] OP_RATE = 4'd0;
  localparam logic [3:0] OP_P00  = 4'd1;
  localparam logic [3:0] OP_P01  = 4'd2;
  localparam logic [3:0] OP_P10  = 4'd3;
  localparam logic [3:0] OP_P11  = 4'd4;
  localparam logic [3:0] OP_C00  = 4'd5;
  localparam logic [3:0] OP_C01  = 4'd6;
  localparam logic [3:0] OP_C10  = 4'd7;
  localparam logic [3:0] OP_C11  = 4'd8;
  localparam logic [3:0] OP_ANG  = 4'd9;
  localparam logic [3:0] OP_BIAS = 4'd10;

  localparam logic [1:0] MCNT_LAST = 2'(takf_pkg::COV_W / takf_pkg::DIGIT_W - 1);
  localparam logic [5:0] DIV_LAST  = 6'(takf_pkg::COV_W - 1);
  localparam int         PW        = takf_pkg::PROD_W;
  localparam int         CW        = takf_pkg::COV_W;
  localparam int         OPND_MSB  = takf_pkg::OPND_W - 1;

  logic [2:0] state_r, state_nxt;
  logic [3:0] op_r;
  logic [1:0] mcnt_r;
  logic [5:0] dcnt_r;
  logic       divsel_r, dneg_r, dzero_r, dovf_r;

  takf_pkg::cfg_t  qa_cfg_r, qg_cfg_r, rm_cfg_r, dt_r;
  takf_pkg::data_t ang_r, bias_r, accel_r, gyro_r;
  takf_pkg::cov_t  p00_r, p01_r, p10_r, p11_r, e_r, t0_r, t1_r, k0_r, k1_r;
  logic signed [takf_pkg::DATA_W:0] err_r;
  logic [PW-1:0] acc_r;
  logic [CW:0]   rem_r;
  logic [CW-1:0] dvd_r, q_r, dmd_r;
  logic          out_valid_r;
  takf_pkg::data_t out_ang_r, out_rate_r;

  // Prediction terms taken from the covariance before it is updated.
  logic signed [takf_pkg::DATA_W:0] rate;
  takf_pkg::cov_t qa, qg, rm, d0, negp11;

  always_comb begin
    rate   = {gyro_r[takf_pkg::DATA_W-1], gyro_r} - {bias_r[takf_pkg::DATA_W-1], bias_r};
    qa     = {{takf_pkg::CFG_PAD_W{1'b0}}, qa_cfg_r, {takf_pkg::CFG_SHIFT{1'b0}}};
    qg     = {{takf_pkg::CFG_PAD_W{1'b0}}, qg_cfg_r, {takf_pkg::CFG_SHIFT{1'b0}}};
    rm     = {{takf_pkg::CFG_PAD_W{1'b0}}, rm_cfg_r, {takf_pkg::CFG_SHIFT{1'b0}}};
    d0     = takf_pkg::sat_cov(takf_pkg::wide_t'(takf_pkg::sat_cov(
               takf_pkg::wide_t'(qa) - takf_pkg::wide_t'(p01_r)))
               - takf_pkg::wide_t'(p10_r));
    negp11 = takf_pkg::sat_cov(-takf_pkg::wide_t'(p11_r));
  end

  // Shared multiplier operands.
  takf_pkg::opnd_t op_a, op_b, ma_full, mb_full;
  logic [CW-1:0]   ma, mb;
  logic            mneg;
  logic [takf_pkg::DIGIT_W-1:0] digit;
  logic [CW+takf_pkg::DIGIT_W-1:0] part;
  logic [PW-1:0]   pp, acc_nxt;

  always_comb begin
    case (op_r)
      OP_RATE: begin
        op_a = takf_pkg::opnd_t'(rate);
        op_b = takf_pkg::opnd_t'({1'b0, dt_r});
      end
      OP_P00: begin
        op_a = takf_pkg::opnd_t'(d0);
        op_b = takf_pkg::opnd_t'({1'b0, dt_r});
      end
      OP_P01, OP_P10: begin
        op_a = takf_pkg::opnd_t'(negp11);
        op_b = takf_pkg::opnd_t'({1'b0, dt_r});
      end
      OP_P11: begin
        op_a = takf_pkg::opnd_t'(qg);
        op_b = takf_pkg::opnd_t'({1'b0, dt_r});
      end
      OP_C00: begin
        op_a = takf_pkg::opnd_t'(k0_r);
        op_b = takf_pkg::opnd_t'(t0_r);
      end
      OP_C01: begin
        op_a = takf_pkg::opnd_t'(k0_r);
        op_b = takf_pkg::opnd_t'(t1_r);
      end
      OP_C10: begin
        op_a = takf_pkg::opnd_t'(k1_r);
        op_b = takf_pkg::opnd_t'(t0_r);
      end
      OP_C11: begin
        op_a = takf_pkg::opnd_t'(k1_r);
        op_b = takf_pkg::opnd_t'(t1_r);
      end
      OP_ANG: begin
        op_a = takf_pkg::opnd_t'(k0_r);
        op_b = takf_pkg::opnd_t'(err_r);
      end
      OP_BIAS: begin
        op_a = takf_pkg::opnd_t'(k1_r);
        op_b = takf_pkg::opnd_t'(err_r);
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
    ma_full = op_a[OPND_MSB] ? -op_a : op_a;
    mb_full = op_b[OPND_MSB] ? -op_b : op_b;
    ma      = ma_full[CW-1:0];
    mb      = mb_full[CW-1:0];
    mneg    = op_a[OPND_MSB] ^ op_b[OPND_MSB];
    case (mcnt_r)
      2'd0:    digit = mb[15:0];
      2'd1:    digit = mb[31:16];
      default: digit = mb[47:32];
    endcase
    part = ma * digit;
    case (mcnt_r)
      2'd0:    pp = PW'(part);
      2'd1:    pp = PW'(part) << takf_pkg::DIGIT_W;
      default: pp = PW'(part) << (2 * takf_pkg::DIGIT_W);
    endcase
    acc_nxt = ((mcnt_r == 2'd0) ? '0 : acc_r) + pp;
  end

  // Rounding half away from zero and saturation of the product.
  logic          sh24, sat_op, movf;
  logic [PW:0]   rsum, rmag;
  logic [CW+1:0] mag_u;
  takf_pkg::wide_t mres;

  always_comb begin
    sh24   = (op_r <= OP_P11);
    sat_op = (op_r >= OP_P00) && (op_r <= OP_C11);
    if (sh24) begin
      rsum = {1'b0, acc_r} + ((PW+1)'(1) << (takf_pkg::CFG_FRAC - 1));
      rmag = rsum >> takf_pkg::CFG_FRAC;
    end else begin
      rsum = {1'b0, acc_r} + ((PW+1)'(1) << (takf_pkg::COV_FRAC - 1));
      rmag = rsum >> takf_pkg::COV_FRAC;
    end
    movf = |rmag[PW:CW-1];
    if (sat_op && movf) begin
      mag_u = mneg ? (CW+2)'({1'b1, {(CW-1){1'b0}}}) : (CW+2)'({(CW-1){1'b1}});
    end else begin
      mag_u = rmag[CW+1:0];
    end
    mres = mneg ? -takf_pkg::wide_t'({1'b0, mag_u}) : takf_pkg::wide_t'({1'b0, mag_u});
  end

  // Divider setup and finish.
  takf_pkg::cov_t  dn;
  takf_pkg::opnd_t dn_full, dd_full;
  logic [CW-1:0]   nmag, dmag;
  logic            dbig;
  logic [CW:0]     r2, q1;
  logic            rge, rnd_up, ksat;
  logic [CW-1:0]   kmag;
  takf_pkg::opnd_t kfull;
  takf_pkg::cov_t  kval;

  always_comb begin
    dn      = divsel_r ? p10_r : p00_r;
    dn_full = takf_pkg::opnd_t'(dn);
    dd_full = takf_pkg::opnd_t'(e_r);
    dn_full = dn_full[OPND_MSB] ? -dn_full : dn_full;
    dd_full = dd_full[OPND_MSB] ? -dd_full : dd_full;
    nmag    = dn_full[CW-1:0];
    dmag    = dd_full[CW-1:0];
    // Quotient bits above the result width are all zero only if n < d * 2^16.
    dbig    = {16'b0, nmag} >= {dmag, 16'b0};
    r2      = {rem_r[CW-1:0], dvd_r[CW-1]};
    rge     = r2 >= {1'b0, dmd_r};
    rnd_up  = rem_r >= ({1'b0, dmd_r} - rem_r);
    q1      = {1'b0, q_r} + (CW+1)'(rnd_up);
    ksat    = dovf_r || (q1 > (CW+1)'({(CW-1){1'b1}}));
    if (ksat) begin
      kmag = dneg_r ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
    end else begin
      kmag = q1[CW-1:0];
    end
    kfull = dneg_r ? -takf_pkg::opnd_t'({1'b0, kmag}) : takf_pkg::opnd_t'({1'b0, kmag});
    kval  = dzero_r ? '0 : kfull[CW-1:0];
  end

  logic out_load;
  assign out_load = (state_r == ST_DONE) && (!out_valid_r || out_ready);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:   if (in_valid) state_nxt = ST_MUL;
      ST_MUL:    if (mcnt_r == MCNT_LAST) state_nxt = ST_MAPPLY;
      ST_MAPPLY: begin
        if (op_r == OP_P11) state_nxt = ST_PREP;
        else if (op_r == OP_BIAS) state_nxt = ST_DONE;
        else state_nxt = ST_MUL;
      end
      ST_PREP:   state_nxt = ST_DSET;
      ST_DSET:   state_nxt = (e_r == '0 || dbig) ? ST_DFIN : ST_DIV;
      ST_DIV:    if (dcnt_r == DIV_LAST) state_nxt = ST_DFIN;
      ST_DFIN:   state_nxt = divsel_r ? ST_MUL : ST_DSET;
      ST_DONE:   if (out_load) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      op_r        <= OP_RATE;
      mcnt_r      <= '0;
      dcnt_r      <= '0;
      divsel_r    <= 1'b0;
      out_valid_r <= 1'b0;
      qa_cfg_r    <= takf_pkg::RST_ANGLE_NOISE;
      qg_cfg_r    <= takf_pkg::RST_BIAS_NOISE;
      rm_cfg_r    <= takf_pkg::RST_MEAS_NOISE;
      dt_r        <= takf_pkg::RST_TIME_STEP;
      ang_r       <= '0;
      bias_r      <= '0;
      p00_r       <= takf_pkg::COV_ONE;
      p01_r       <= '0;
      p10_r       <= '0;
      p11_r       <= takf_pkg::COV_ONE;
    end else begin
      state_r <= state_nxt;

      if (cfg_wr_en) begin
        case (cfg_index)
          takf_pkg::REG_ANGLE_NOISE: qa_cfg_r <= cfg_wdata;
          takf_pkg::REG_BIAS_NOISE:  qg_cfg_r <= cfg_wdata;
          takf_pkg::REG_MEAS_NOISE:  rm_cfg_r <= cfg_wdata;
          takf_pkg::REG_TIME_STEP:   dt_r     <= cfg_wdata;
          default: ;
        endcase
      end

      if (out_load) begin
        out_valid_r <= 1'b1;
        out_ang_r   <= ang_r;
        out_rate_r  <= takf_pkg::sat_data(takf_pkg::wide_t'(gyro_r)
                                          - takf_pkg::wide_t'(bias_r));
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            accel_r <= in_accel_angle;
            gyro_r  <= in_gyro_rate;
            op_r    <= OP_RATE;
            mcnt_r  <= '0;
          end
        end
        ST_MUL: begin
          acc_r  <= acc_nxt;
          mcnt_r <= (mcnt_r == MCNT_LAST) ? 2'd0 : mcnt_r + 2'd1;
        end
        ST_MAPPLY: begin
          case (op_r)
            OP_RATE, OP_ANG:
              ang_r <= takf_pkg::sat_data(takf_pkg::wide_t'(ang_r) + mres);
            OP_BIAS:
              bias_r <= takf_pkg::sat_data(takf_pkg::wide_t'(bias_r) + mres);
            OP_P00: p00_r <= takf_pkg::sat_cov(takf_pkg::wide_t'(p00_r) + mres);
            OP_P01: p01_r <= takf_pkg::sat_cov(takf_pkg::wide_t'(p01_r) + mres);
            OP_P10: p10_r <= takf_pkg::sat_cov(takf_pkg::wide_t'(p10_r) + mres);
            OP_P11: p11_r <= takf_pkg::sat_cov(takf_pkg::wide_t'(p11_r) + mres);
            OP_C00: p00_r <= takf_pkg::sat_cov(takf_pkg::wide_t'(p00_r) - mres);
            OP_C01: p01_r <= takf_pkg::sat_cov(takf_pkg::wide_t'(p01_r) - mres);
            OP_C10: p10_r <= takf_pkg::sat_cov(takf_pkg::wide_t'(p10_r) - mres);
            OP_C11: p11_r <= takf_pkg::sat_cov(takf_pkg::wide_t'(p11_r) - mres);
            default: ;
          endcase
          op_r <= op_r + 4'd1;
        end
        ST_PREP: begin
          err_r    <= {accel_r[takf_pkg::DATA_W-1], accel_r}
                      - {ang_r[takf_pkg::DATA_W-1], ang_r};
          e_r      <= takf_pkg::sat_cov(takf_pkg::wide_t'(rm) + takf_pkg::wide_t'(p00_r));
          t0_r     <= p00_r;
          t1_r     <= p01_r;
          divsel_r <= 1'b0;
        end
        ST_DSET: begin
          dneg_r  <= dn[CW-1] ^ e_r[CW-1];
          dzero_r <= (e_r == '0);
          dovf_r  <= dbig;
          dmd_r   <= dmag;
          rem_r   <= (CW+1)'(nmag >> takf_pkg::DIGIT_W);
          dvd_r   <= {nmag[takf_pkg::DIGIT_W-1:0], {(CW-takf_pkg::DIGIT_W){1'b0}}};
          q_r     <= '0;
          dcnt_r  <= '0;
        end
        ST_DIV: begin
          rem_r  <= rge ? r2 - {1'b0, dmd_r} : r2;
          q_r    <= {q_r[CW-2:0], rge};
          dvd_r  <= dvd_r << 1;
          dcnt_r <= dcnt_r + 6'd1;
        end
        ST_DFIN: begin
          if (divsel_r) begin
            k1_r   <= kval;
            op_r   <= OP_C00;
            mcnt_r <= '0;
          end else begin
            k0_r     <= kval;
            divsel_r <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  assign in_ready           = (state_r == ST_IDLE);
  assign out_valid          = out_valid_r;
  assign out_filtered_angle = out_ang_r;
  assign out_corrected_rate = out_rate_r;

  `ASSERT_NEXT(a_accept_starts_rate, in_valid && in_ready, state_r == ST_MUL && op_r == OP_RATE && mcnt_r == 2'd0, "accepted beat did not start the rate multiply")
  `ASSERT_IMPLIES(a_div_count_bound, state_r == ST_DIV, dcnt_r <= DIV_LAST, "divider ran past its last step")
  `ASSERT_IMPLIES(a_result_from_done, $rose(out_valid), $past(state_r) == ST_DONE, "result beat raised outside the final step")

endmodule
